@@ hw/rtl/crsd_pkg.sv @@
// shared types and constants for the column rle sprite decoder
package crsd_pkg;

  localparam int COORD_BITS = 10;
  localparam int BYTE_W     = 8;
  localparam int XY_W       = 10;
  localparam int CFG_W      = 10;
  localparam int SIZE_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int REP_W      = 6;
  localparam int KIND_W     = 2;
  localparam int ERR_W      = 3;

  localparam logic [CFG_W-1:0]  WIDTH_RST  = 10'd320;
  localparam logic [CFG_W-1:0]  HEIGHT_RST = 10'd200;
  localparam logic [SIZE_W-1:0] COLORS_RST = 9'd256;

  localparam logic [BYTE_W-1:0] BYTE_EMPTY    = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_RUN      = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_RUN_REP  = 8'h80;
  localparam logic [BYTE_W-1:0] BYTE_REP_MIN  = 8'hE0;
  localparam logic [BYTE_W-1:0] BYTE_REP_BIAS = 8'hDF;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_ERROR  = 2'd2
  } result_kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE        = 3'd0,
    ERR_DIRECTIVE   = 3'd1,
    ERR_REPEAT_ZERO = 3'd2,
    ERR_Y_RANGE     = 3'd3,
    ERR_COLOR_RANGE = 3'd4
  } error_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_COLORS = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_COLUMN   = 3'd1,
    ST_ROWCOUNT = 3'd2,
    ST_SEQCOUNT = 3'd3,
    ST_DELTA    = 3'd4,
    ST_PIXEL    = 3'd5,
    ST_REPEAT   = 3'd6,
    ST_BURST    = 3'd7
  } crsd_state_e;

  typedef struct packed {
    logic         frame_start;
    logic         col_start;
    logic         rep_col;
    logic         load_row;
    logic         load_seq;
    logic         dec_row;
    logic         dec_seq;
    logic         add_delta;
    logic         row_inc;
    logic         col_inc;
    logic         load_rep_cnt;
    logic         load_rep_color;
    logic         dec_rep;
    logic         set_err;
    error_code_e  err_code;
    logic         out_load;
    result_kind_e out_kind;
    logic         out_err_latched;
    logic         out_color_rep;
    logic         out_warn;
    logic         out_done;
    logic         out_last;
  } crsd_cmd_t;

  typedef struct packed {
    logic sof;
    logic byte_empty;
    logic byte_run;
    logic byte_rep_mark;
    logic byte_rep;
    logic byte_zero;
    logic byte_color_bad;
    logic rep_zero;
    logic rep_color_bad;
    logic y_bad;
    logic row_zero;
    logic row_le1;
    logic seq_zero;
    logic seq_le1;
    logic col_end;
    logic width_zero;
    logic rep_last;
    logic rep_cnt_zero;
    logic rep_col;
    logic err_latched;
    logic slot_free;
  } crsd_status_t;

endpackage

@@ hw/rtl/crsd_if.sv @@
// stream channel interfaces for encoded bytes and decoded results
interface crsd_in_if import crsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_of_frame;

  modport source (output valid, data_byte, start_of_frame, input ready);
  modport sink   (input valid, data_byte, start_of_frame, output ready);
endinterface

interface crsd_out_if import crsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [XY_W-1:0]   column_x;
  logic [XY_W-1:0]   row_y;
  logic [BYTE_W-1:0] pixel_color;
  logic [ERR_W-1:0]  error_code;
  logic              color_zero_warning;
  logic              frame_done;
  logic              last;

  modport source (output valid, result_kind, column_x, row_y, pixel_color, error_code,
                  color_zero_warning, frame_done, last, input ready);
  modport sink   (input valid, result_kind, column_x, row_y, pixel_color, error_code,
                  color_zero_warning, frame_done, last, output ready);
endinterface

@@ hw/rtl/crsd_datapath.sv @@
// decoder datapath: config, counters, position, error latch and result register
module crsd_datapath import crsd_pkg::*; #(
  parameter int CoordBits = COORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic                 sof_i,
  input  crsd_cmd_t            cmd_i,
  output crsd_status_t         status_o,
  crsd_out_if.source           out_o
);

  localparam int CmpW = (CoordBits > CFG_W) ? CoordBits : CFG_W;
  localparam logic [CoordBits-1:0] RowMax = {CoordBits{1'b1}};

  logic [CFG_W-1:0]     width_q, width_d;
  logic [CFG_W-1:0]     height_q, height_d;
  logic [SIZE_W-1:0]    colors_q, colors_d;
  logic                 rep_col_q, rep_col_d;
  logic [BYTE_W-1:0]    row_left_q, row_left_d;
  logic [BYTE_W-1:0]    seq_left_q, seq_left_d;
  logic [XY_W-1:0]      col_q, col_d;
  logic [CoordBits-1:0] row_q, row_d;
  logic [REP_W-1:0]     rep_cnt_q, rep_cnt_d;
  logic [BYTE_W-1:0]    rep_color_q, rep_color_d;
  logic                 err_latched_q, err_latched_d;
  error_code_e          err_code_q, err_code_d;
  logic                 out_valid_q, out_valid_d;

  result_kind_e         kind_q;
  logic [XY_W-1:0]      col_out_q;
  logic [XY_W-1:0]      row_out_q;
  logic [BYTE_W-1:0]    color_out_q;
  error_code_e          err_out_q;
  logic                 warn_q, done_q, last_q;

  logic [CoordBits:0]   row_sum;
  logic [XY_W-1:0]      col_plus;
  logic                 slot_free;
  logic                 has_pos;

  assign row_sum   = {1'b0, row_q} + (CoordBits+1)'(data_byte_i);
  assign col_plus  = col_q + XY_W'(1);
  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    status_o.sof            = sof_i;
    status_o.byte_empty     = (data_byte_i == BYTE_EMPTY);
    status_o.byte_run       = (data_byte_i == BYTE_RUN) || (data_byte_i == BYTE_RUN_REP);
    status_o.byte_rep_mark  = (data_byte_i == BYTE_RUN_REP);
    status_o.byte_rep       = (data_byte_i >= BYTE_REP_MIN);
    status_o.byte_zero      = (data_byte_i == '0);
    status_o.byte_color_bad = ({1'b0, data_byte_i} >= colors_q);
    status_o.rep_zero       = (rep_color_q == '0);
    status_o.rep_color_bad  = ({1'b0, rep_color_q} >= colors_q);
    status_o.y_bad          = (CmpW'(row_q) >= CmpW'(height_q));
    status_o.row_zero       = (row_left_q == '0);
    status_o.row_le1        = (row_left_q <= BYTE_W'(1));
    status_o.seq_zero       = (seq_left_q == '0);
    status_o.seq_le1        = (seq_left_q <= BYTE_W'(1));
    status_o.col_end        = (col_plus >= width_q);
    status_o.width_zero     = (width_q == '0);
    status_o.rep_last       = (rep_cnt_q == REP_W'(1));
    status_o.rep_cnt_zero   = (rep_cnt_q == '0);
    status_o.rep_col        = rep_col_q;
    status_o.err_latched    = err_latched_q;
    status_o.slot_free      = slot_free;
  end

  // configuration
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    colors_d = colors_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_d  = cfg_data_i;
        CFG_HEIGHT: height_d = cfg_data_i;
        CFG_COLORS: colors_d = cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // decode state
  always_comb begin
    rep_col_d     = rep_col_q;
    row_left_d    = row_left_q;
    seq_left_d    = seq_left_q;
    col_d         = col_q;
    row_d         = row_q;
    rep_cnt_d     = rep_cnt_q;
    rep_color_d   = rep_color_q;
    err_latched_d = err_latched_q;
    err_code_d    = err_code_q;
    if (cmd_i.frame_start) begin
      rep_col_d     = 1'b0;
      row_left_d    = '0;
      seq_left_d    = '0;
      col_d         = '0;
      row_d         = '0;
      rep_cnt_d     = '0;
      err_latched_d = 1'b0;
      err_code_d    = ERR_NONE;
    end else begin
      if (cmd_i.col_start) begin
        rep_col_d = cmd_i.rep_col;
        row_d     = '0;
      end
      if (cmd_i.load_row) row_left_d = data_byte_i;
      if (cmd_i.load_seq) seq_left_d = data_byte_i;
      if (cmd_i.dec_row && row_left_q != '0) row_left_d = row_left_q - BYTE_W'(1);
      if (cmd_i.dec_seq && seq_left_q != '0) seq_left_d = seq_left_q - BYTE_W'(1);
      if (cmd_i.add_delta) row_d = row_sum[CoordBits] ? RowMax : row_sum[CoordBits-1:0];
      if (cmd_i.row_inc && row_q != RowMax) row_d = row_q + CoordBits'(1);
      if (cmd_i.col_inc) col_d = col_plus;
      if (cmd_i.load_rep_cnt) rep_cnt_d = REP_W'(data_byte_i - BYTE_REP_BIAS);
      if (cmd_i.dec_rep) rep_cnt_d = rep_cnt_q - REP_W'(1);
      if (cmd_i.load_rep_color) rep_color_d = data_byte_i;
      if (cmd_i.set_err) begin
        err_latched_d = 1'b1;
        err_code_d    = cmd_i.err_code;
      end
    end
  end

  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  assign has_pos     = (cmd_i.out_kind != KIND_STATUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= WIDTH_RST;
      height_q      <= HEIGHT_RST;
      colors_q      <= COLORS_RST;
      rep_col_q     <= 1'b0;
      row_left_q    <= '0;
      seq_left_q    <= '0;
      col_q         <= '0;
      row_q         <= '0;
      rep_cnt_q     <= '0;
      err_latched_q <= 1'b0;
      err_code_q    <= ERR_NONE;
      out_valid_q   <= 1'b0;
    end else begin
      width_q       <= width_d;
      height_q      <= height_d;
      colors_q      <= colors_d;
      rep_col_q     <= rep_col_d;
      row_left_q    <= row_left_d;
      seq_left_q    <= seq_left_d;
      col_q         <= col_d;
      row_q         <= row_d;
      rep_cnt_q     <= rep_cnt_d;
      err_latched_q <= err_latched_d;
      err_code_q    <= err_code_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    rep_color_q <= rep_color_d;
    if (cmd_i.out_load) begin
      kind_q    <= cmd_i.out_kind;
      col_out_q <= has_pos ? col_q : '0;
      row_out_q <= has_pos ? XY_W'(row_q) : '0;
      if (cmd_i.out_kind == KIND_PIXEL) begin
        color_out_q <= cmd_i.out_color_rep ? rep_color_q : data_byte_i;
      end else begin
        color_out_q <= '0;
      end
      if (cmd_i.out_kind == KIND_ERROR) begin
        err_out_q <= cmd_i.out_err_latched ? err_code_q : cmd_i.err_code;
      end else begin
        err_out_q <= ERR_NONE;
      end
      warn_q <= cmd_i.out_warn;
      done_q <= cmd_i.out_done;
      last_q <= cmd_i.out_last;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.result_kind        = kind_q;
  assign out_o.column_x           = col_out_q;
  assign out_o.row_y              = row_out_q;
  assign out_o.pixel_color        = color_out_q;
  assign out_o.error_code         = err_out_q;
  assign out_o.color_zero_warning = warn_q;
  assign out_o.frame_done         = done_q;
  assign out_o.last               = last_q;

endmodule

@@ hw/rtl/crsd_controller.sv @@
// decoder controller: phase state machine and command generation
module crsd_controller import crsd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  crsd_status_t status_i,
  output crsd_cmd_t    cmd_o
);

  crsd_state_e state_q, state_d;
  crsd_state_e col_next;
  logic        fire;
  logic        emit;

  assign in_ready_o = (state_q != ST_BURST) && status_i.slot_free;
  assign fire       = in_valid_i && in_ready_o;
  assign emit       = (state_q == ST_BURST) && status_i.slot_free;
  assign col_next   = status_i.col_end ? ST_IDLE : ST_COLUMN;

  // next state
  always_comb begin
    state_d = state_q;
    if (fire && status_i.sof) begin
      state_d = status_i.width_zero ? ST_IDLE : ST_COLUMN;
    end else if (fire) begin
      case (state_q)
        ST_COLUMN: begin
          if (status_i.byte_empty) state_d = col_next;
          else if (status_i.byte_run) state_d = ST_ROWCOUNT;
          else state_d = ST_IDLE;
        end
        ST_ROWCOUNT: state_d = status_i.byte_zero ? col_next : ST_SEQCOUNT;
        ST_SEQCOUNT: state_d = ST_DELTA;
        ST_DELTA: begin
          if (status_i.seq_zero) state_d = status_i.row_le1 ? col_next : ST_SEQCOUNT;
          else state_d = ST_PIXEL;
        end
        ST_PIXEL: begin
          if (status_i.rep_col && status_i.byte_rep) begin
            state_d = ST_REPEAT;
          end else if (status_i.y_bad || status_i.byte_color_bad) begin
            state_d = ST_IDLE;
          end else if (status_i.seq_le1) begin
            state_d = status_i.row_le1 ? col_next : ST_SEQCOUNT;
          end else begin
            state_d = ST_PIXEL;
          end
        end
        ST_REPEAT: state_d = ST_BURST;
        default: ;
      endcase
    end else if (emit) begin
      if (status_i.rep_zero || status_i.y_bad || status_i.rep_color_bad) begin
        state_d = ST_IDLE;
      end else if (status_i.rep_last) begin
        if (status_i.seq_zero) state_d = status_i.row_zero ? col_next : ST_SEQCOUNT;
        else state_d = ST_PIXEL;
      end
    end
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = KIND_STATUS;
    cmd_o.err_code = ERR_NONE;
    if (fire) begin
      cmd_o.out_load = 1'b1;
      cmd_o.out_last = 1'b1;
      if (status_i.sof) begin
        cmd_o.frame_start = 1'b1;
        cmd_o.out_done    = status_i.width_zero;
      end else begin
        case (state_q)
          ST_IDLE: begin
            if (status_i.err_latched) begin
              cmd_o.out_kind        = KIND_ERROR;
              cmd_o.out_err_latched = 1'b1;
            end
          end
          ST_COLUMN: begin
            if (status_i.byte_empty) begin
              cmd_o.col_inc  = 1'b1;
              cmd_o.out_done = status_i.col_end;
            end else if (status_i.byte_run) begin
              cmd_o.col_start = 1'b1;
              cmd_o.rep_col   = status_i.byte_rep_mark;
            end else begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = ERR_DIRECTIVE;
              cmd_o.out_kind = KIND_ERROR;
            end
          end
          ST_ROWCOUNT: begin
            cmd_o.load_row = 1'b1;
            if (status_i.byte_zero) begin
              cmd_o.col_inc  = 1'b1;
              cmd_o.out_done = status_i.col_end;
            end
          end
          ST_SEQCOUNT: begin
            cmd_o.load_seq = 1'b1;
            cmd_o.dec_row  = 1'b1;
          end
          ST_DELTA: begin
            cmd_o.dec_row   = 1'b1;
            cmd_o.add_delta = 1'b1;
            if (status_i.seq_zero && status_i.row_le1) begin
              cmd_o.col_inc  = 1'b1;
              cmd_o.out_done = status_i.col_end;
            end
          end
          ST_PIXEL: begin
            cmd_o.dec_row = 1'b1;
            cmd_o.dec_seq = 1'b1;
            if (status_i.rep_col && status_i.byte_rep) begin
              cmd_o.load_rep_cnt = 1'b1;
            end else begin
              cmd_o.out_warn = status_i.byte_zero;
              if (status_i.y_bad) begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = ERR_Y_RANGE;
                cmd_o.out_kind = KIND_ERROR;
              end else if (status_i.byte_color_bad) begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = ERR_COLOR_RANGE;
                cmd_o.out_kind = KIND_ERROR;
              end else begin
                cmd_o.out_kind = KIND_PIXEL;
                cmd_o.row_inc  = 1'b1;
                if (status_i.seq_le1 && status_i.row_le1) begin
                  cmd_o.col_inc  = 1'b1;
                  cmd_o.out_done = status_i.col_end;
                end
              end
            end
          end
          ST_REPEAT: begin
            cmd_o.dec_row        = 1'b1;
            cmd_o.dec_seq        = 1'b1;
            cmd_o.load_rep_color = 1'b1;
            cmd_o.out_load       = 1'b0;
          end
          default: ;
        endcase
      end
    end else if (emit) begin
      cmd_o.out_load      = 1'b1;
      cmd_o.out_color_rep = 1'b1;
      cmd_o.out_last      = 1'b1;
      if (status_i.rep_zero) begin
        cmd_o.set_err  = 1'b1;
        cmd_o.err_code = ERR_REPEAT_ZERO;
        cmd_o.out_kind = KIND_ERROR;
      end else if (status_i.y_bad) begin
        cmd_o.set_err  = 1'b1;
        cmd_o.err_code = ERR_Y_RANGE;
        cmd_o.out_kind = KIND_ERROR;
      end else if (status_i.rep_color_bad) begin
        cmd_o.set_err  = 1'b1;
        cmd_o.err_code = ERR_COLOR_RANGE;
        cmd_o.out_kind = KIND_ERROR;
      end else begin
        cmd_o.out_kind = KIND_PIXEL;
        cmd_o.row_inc  = 1'b1;
        cmd_o.dec_rep  = 1'b1;
        cmd_o.out_last = status_i.rep_last;
        if (status_i.rep_last && status_i.seq_zero && status_i.row_zero) begin
          cmd_o.col_inc  = 1'b1;
          cmd_o.out_done = status_i.col_end;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_burst_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BURST) |-> !status_i.rep_cnt_zero)
    else $error("repeat burst with empty count");
  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.err_latched |-> (state_q == ST_IDLE))
    else $error("decoding continues after latched error");
  a_partial_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && !cmd_o.out_last) |-> (state_q == ST_BURST))
    else $error("non-final result outside a repeat burst");
  a_repeat_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !status_i.sof && state_q == ST_REPEAT) |=> !status_i.rep_cnt_zero)
    else $error("repeat color taken with no pending count");
`endif

endmodule

@@ hw/rtl/column_rle_sprite_decoder.sv @@
// top level of the column rle sprite decoder
// output: the result of a byte transfer is registered and shows in the cycle after it; the
//   results of a repeat color byte come from the burst state after the transfer
// throughput: one byte per cycle while the output slot is free; a repeat color byte then
//   emits one result per cycle likewise, 1 to 32 set by the repeat code, and holds off input
// reset: asynchronous active low; decoder idle awaiting a frame code, config and decode registers at defaults
module column_rle_sprite_decoder import crsd_pkg::*; #(
  parameter int CoordBits = COORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  crsd_in_if.sink              in_i,
  crsd_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  crsd_cmd_t    cmd;
  crsd_status_t status;
  logic         in_ready;

  assign in_i.ready = in_ready;

  crsd_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  crsd_datapath #(
    .CoordBits (CoordBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .data_byte_i (in_i.data_byte),
    .sof_i       (in_i.start_of_frame),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_o       (out_o)
  );

endmodule
